// ===== src/framed_axis_median_receiver_defines.svh =====
// Assertion macros shared by the median receiver modules
`ifndef FRAMED_AXIS_MEDIAN_RECEIVER_DEFINES_SVH
`define FRAMED_AXIS_MEDIAN_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FAM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FAM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fam_pkg.sv =====
// Shared constants, types and command struct of the median receiver
package fam_pkg;

  // History ring length and derived widths
  localparam int WINDOW = 8;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int AXES   = 2;

  // Value constants
  localparam logic [7:0]  AXIS_MAX  = 8'd200;
  localparam logic [7:0]  ZERO_CODE = 8'd100;
  localparam logic [10:0] TICK_MAX  = 11'd2047;
  localparam logic [15:0] TALLY_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [7:0] START_CODE_RST    = 8'd255;
  localparam logic [9:0] SILENCE_LIMIT_RST = 10'd100;

  // Configuration register indexes
  typedef enum logic {
    CFG_START_CODE    = 1'b0,
    CFG_SILENCE_LIMIT = 1'b1
  } cfg_idx_e;

  // Item opcodes
  localparam logic OP_BYTE = 1'b0;

  // Frame phase
  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_AX0  = 3'b010,
    PH_AX1  = 3'b100
  } phase_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic             take;
    logic             scan_step;
    logic             load_out;
    logic [IDX_W-1:0] scan_idx;
  } cmd_t;

endpackage

// ===== src/framed_axis_median_receiver.sv =====
// Top level of the framed two-axis median receiver
//
// Input channel (in_valid_i / in_stall_o): one request per received byte
// (opcode_i = 0, rx_byte_i) or idle tick (opcode_i = 1). The block frames a
// start byte and two axis bytes, keeps an eight-slot history per axis and
// returns one result per request on the output channel (out_valid_o /
// out_stall_i): both axis medians in signed hundredths, link-lost flag,
// frame-done flag and the saturating error and good-sample counts.
// The median scan steps one candidate slot per cycle through the history
// compare unit, both axes side by side; no new request is taken until the
// scan is done and its result is loaded into the output register.
// A new request is taken while the previous result still waits in the
// output register; a stalled result holds and delays only the next load.
// Configuration (cfg_valid_i / cfg_ready_o, always ready): index 0 start
// code, index 1 silence limit; write only while the block is idle.
// Reset: histories read zero, framing waits for a start byte, counters and
// the link-lost flag clear, start code 255, silence limit 100. Once the link
// is lost, only reset brings the block back.
module framed_axis_median_receiver
  import fam_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [7:0] left_axis_median_o,
  output logic signed [7:0] right_axis_median_o,
  output logic              link_lost_o,
  output logic              frame_done_o,
  output logic [15:0]       range_errors_o,
  output logic [15:0]       good_samples_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [9:0]        cfg_data_i
);

  logic [7:0] start_code_q;
  logic [9:0] silence_limit_q;
  cmd_t       cmd;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q    <= START_CODE_RST;
      silence_limit_q <= SILENCE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_CODE:    start_code_q    <= cfg_data_i[7:0];
        CFG_SILENCE_LIMIT: silence_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  fam_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .opcode_i            (opcode_i),
    .rx_byte_i           (rx_byte_i),
    .start_code_i        (start_code_q),
    .silence_limit_i     (silence_limit_q),
    .left_axis_median_o  (left_axis_median_o),
    .right_axis_median_o (right_axis_median_o),
    .link_lost_o         (link_lost_o),
    .frame_done_o        (frame_done_o),
    .range_errors_o      (range_errors_o),
    .good_samples_o      (good_samples_o)
  );

endmodule

// ===== src/fam_ctrl.sv =====
// Controller: request sequencing, median scan counter and output valid
`include "framed_axis_median_receiver_defines.svh"
module fam_ctrl
  import fam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             take, step, load, last;

  // Handshake decode
  assign last = (cnt_q == IDX_W'(WINDOW - 1));
  assign take = (state_q == S_IDLE) && in_valid_i;
  assign step = (state_q == S_SCAN);
  assign load = (state_q == S_LOAD) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.take      = take;
  assign cmd_o.scan_step = step;
  assign cmd_o.load_out  = load;
  assign cmd_o.scan_idx  = cnt_q;

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (take) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (last) begin
          state_d = S_LOAD;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_LOAD: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output slot stays full until the receiver takes it
  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FAM_ASSERT_NOW(a_take_load_excl, clk_i, rst_ni, take, !load, "take and load in one cycle")
  `FAM_ASSERT_NEXT(a_load_sets_valid, clk_i, rst_ni, load, out_valid_q, "loaded result not valid")
  `FAM_ASSERT_NEXT(a_take_starts_scan, clk_i, rst_ni, take,
                   (state_q == S_SCAN) && (cnt_q == '0), "scan did not start at slot zero")

endmodule

// ===== src/fam_dp.sv =====
// Datapath: framing, histories, tallies, median scan and result register
`include "framed_axis_median_receiver_defines.svh"
module fam_dp
  import fam_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               opcode_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [7:0]         start_code_i,
  input  logic [9:0]         silence_limit_i,
  output logic signed [7:0]  left_axis_median_o,
  output logic signed [7:0]  right_axis_median_o,
  output logic               link_lost_o,
  output logic               frame_done_o,
  output logic [15:0]        range_errors_o,
  output logic [15:0]        good_samples_o
);

  logic [7:0]       hist_q [AXES][WINDOW];
  logic [7:0]       hist_d [AXES][WINDOW];
  logic [IDX_W-1:0] slot_q, slot_d;
  phase_e           phase_q, phase_d;
  logic             seen_q, seen_d;
  logic [10:0]      ticks_q, ticks_d;
  logic             dis_q, dis_d;
  logic [15:0]      err_q, err_d;
  logic [15:0]      good_q, good_d;
  logic             done_q, done_d;
  logic [10:0]      ticks_inc;
  logic             axis_sel;

  // Scan state per axis
  logic             found_q [AXES];
  logic [7:0]       med_q   [AXES];
  logic [7:0]       cand    [AXES];
  logic [CNT_W-1:0] hi_cnt  [AXES];
  logic [CNT_W-1:0] lo_cnt  [AXES];
  logic [CNT_W-1:0] eq_cnt  [AXES];
  logic [CNT_W-1:0] diff    [AXES];
  logic             qual    [AXES];

  // Result register
  logic [7:0]  res_left_q, res_right_q;
  logic        res_lost_q, res_done_q;
  logic [15:0] res_err_q, res_good_q;

  assign ticks_inc = (ticks_q < TICK_MAX) ? ticks_q + 11'd1 : ticks_q;
  assign axis_sel  = (phase_q == PH_AX1);

  // Item update, applied at the accepting edge
  always_comb begin
    hist_d  = hist_q;
    slot_d  = slot_q;
    phase_d = phase_q;
    seen_d  = seen_q;
    ticks_d = ticks_q;
    dis_d   = dis_q;
    err_d   = err_q;
    good_d  = good_q;
    done_d  = 1'b0;
    if (opcode_i == OP_BYTE && !dis_q) begin
      seen_d = 1'b1;
      if (phase_q == PH_WAIT) begin
        if (rx_byte_i == start_code_i) begin
          phase_d = PH_AX0;
          ticks_d = '0;
        end
      end else begin
        if (rx_byte_i > AXIS_MAX) begin
          if (err_q < TALLY_MAX) err_d = err_q + 16'd1;
        end else begin
          if (good_q < TALLY_MAX) good_d = good_q + 16'd1;
          hist_d[axis_sel][slot_q] = rx_byte_i;
        end
        if (!axis_sel) begin
          phase_d = PH_AX1;
        end else begin
          phase_d = PH_WAIT;
          done_d  = 1'b1;
          slot_d  = (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + IDX_W'(1);
        end
      end
    end else if (seen_q) begin
      ticks_d = ticks_inc;
      if (ticks_inc > {1'b0, silence_limit_i}) begin
        for (int a = 0; a < AXES; a++) begin
          for (int j = 0; j < WINDOW; j++) begin
            hist_d[a][j] = ZERO_CODE;
          end
        end
        dis_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        for (int j = 0; j < WINDOW; j++) begin
          hist_q[a][j] <= ZERO_CODE;
        end
      end
      slot_q  <= '0;
      phase_q <= PH_WAIT;
      seen_q  <= 1'b0;
      ticks_q <= '0;
      dis_q   <= 1'b0;
      err_q   <= '0;
      good_q  <= '0;
      done_q  <= 1'b0;
    end else if (cmd_i.take) begin
      hist_q  <= hist_d;
      slot_q  <= slot_d;
      phase_q <= phase_d;
      seen_q  <= seen_d;
      ticks_q <= ticks_d;
      dis_q   <= dis_d;
      err_q   <= err_d;
      good_q  <= good_d;
      done_q  <= done_d;
    end
  end

  // Candidate at the scan slot against every entry of its ring
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      cand[a]   = hist_q[a][cmd_i.scan_idx];
      hi_cnt[a] = '0;
      lo_cnt[a] = '0;
      eq_cnt[a] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (cand[a] < hist_q[a][j]) begin
          hi_cnt[a] = hi_cnt[a] + CNT_W'(1);
        end else if (cand[a] > hist_q[a][j]) begin
          lo_cnt[a] = lo_cnt[a] + CNT_W'(1);
        end else begin
          eq_cnt[a] = eq_cnt[a] + CNT_W'(1);
        end
      end
      diff[a] = (hi_cnt[a] > lo_cnt[a]) ? hi_cnt[a] - lo_cnt[a] : lo_cnt[a] - hi_cnt[a];
      qual[a] = (diff[a] < eq_cnt[a]);
    end
  end

  // First qualifying slot wins; zero if none does
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        found_q[a] <= 1'b0;
        med_q[a]   <= '0;
      end
    end else if (cmd_i.take) begin
      for (int a = 0; a < AXES; a++) begin
        found_q[a] <= 1'b0;
        med_q[a]   <= '0;
      end
    end else if (cmd_i.scan_step) begin
      for (int a = 0; a < AXES; a++) begin
        if (!found_q[a] && qual[a]) begin
          found_q[a] <= 1'b1;
          med_q[a]   <= cand[a] - ZERO_CODE;
        end
      end
    end
  end

  // Result register, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_left_q  <= med_q[0];
      res_right_q <= med_q[1];
      res_lost_q  <= dis_q;
      res_done_q  <= done_q;
      res_err_q   <= err_q;
      res_good_q  <= good_q;
    end
  end

  assign left_axis_median_o  = $signed(res_left_q);
  assign right_axis_median_o = $signed(res_right_q);
  assign link_lost_o         = res_lost_q;
  assign frame_done_o        = res_done_q;
  assign range_errors_o      = res_err_q;
  assign good_samples_o      = res_good_q;

  `FAM_ASSERT_NEXT(a_lost_sticks, clk_i, rst_ni, dis_q, dis_q, "link lost flag cleared")
  `FAM_ASSERT_NEXT(a_tally_mono, clk_i, rst_ni, 1'b1,
                   (err_q >= $past(err_q)) && (good_q >= $past(good_q)), "tally went down")

endmodule
